### rtl/dcf_pkg.sv
// Shared types, constants and the transition table of the pulse classifier.
package dcf_pkg;

  localparam int NumThresh = 7;
  localparam int ThreshW   = 8;
  localparam int CountW    = 8;
  localparam int CodeW     = 2;
  localparam int ApbDataW  = 32;
  localparam int ApbAddrW  = 5;
  localparam int RegIdxW   = 3;

  typedef logic [ThreshW-1:0] thresh_t;
  typedef thresh_t [NumThresh-1:0] thresh_arr_t;

  localparam thresh_arr_t ThreshReset = {
    8'd220, 8'd120, 8'd95, 8'd25, 8'd17, 8'd15, 8'd6
  };

  typedef enum logic [3:0] {
    S0, S1, S2, S3, S4, S5, S6, S7, S8, S9, S10, S11, S12
  } state_e;

  typedef enum logic [1:0] {
    SYM_MARK,
    SYM_HIGH,
    SYM_LOW
  } sym_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_ZERO,
    ACT_ONE,
    ACT_MINUTE,
    ACT_FAULT
  } act_e;

  localparam logic [CodeW-1:0] CodeZero   = 2'd0;
  localparam logic [CodeW-1:0] CodeOne    = 2'd1;
  localparam logic [CodeW-1:0] CodeMinute = 2'd2;
  localparam logic [CodeW-1:0] CodeFault  = 2'd3;

  typedef struct packed {
    state_e next;
    act_e   act;
  } trans_t;

  function automatic trans_t pick(sym_e sym, trans_t m, trans_t h, trans_t l);
    trans_t r;
    case (sym)
      SYM_MARK: r = m;
      SYM_HIGH: r = h;
      default:  r = l;
    endcase
    return r;
  endfunction

  // (state, symbol) -> (next state, action); columns are mark, high, low
  function automatic trans_t trans_lookup(state_e st, sym_e sym);
    trans_t r;
    unique case (st)
      S0:  r = pick(sym, '{S0,  ACT_FAULT}, '{S1,  ACT_CLEAR},  '{S0,  ACT_NONE});
      S1:  r = pick(sym, '{S2,  ACT_NONE},  '{S1,  ACT_NONE},   '{S0,  ACT_FAULT});
      S2:  r = pick(sym, '{S7,  ACT_NONE},  '{S2,  ACT_NONE},   '{S3,  ACT_NONE});
      S3:  r = pick(sym, '{S4,  ACT_NONE},  '{S0,  ACT_FAULT},  '{S3,  ACT_NONE});
      S4:  r = pick(sym, '{S5,  ACT_NONE},  '{S0,  ACT_FAULT},  '{S4,  ACT_NONE});
      S5:  r = pick(sym, '{S6,  ACT_NONE},  '{S0,  ACT_FAULT},  '{S5,  ACT_NONE});
      S6:  r = pick(sym, '{S11, ACT_ZERO},  '{S0,  ACT_FAULT},  '{S6,  ACT_NONE});
      S7:  r = pick(sym, '{S8,  ACT_NONE},  '{S7,  ACT_NONE},   '{S0,  ACT_FAULT});
      S8:  r = pick(sym, '{S0,  ACT_FAULT}, '{S8,  ACT_NONE},   '{S9,  ACT_NONE});
      S9:  r = pick(sym, '{S10, ACT_NONE},  '{S0,  ACT_FAULT},  '{S9,  ACT_NONE});
      S10: r = pick(sym, '{S11, ACT_ONE},   '{S0,  ACT_FAULT},  '{S10, ACT_NONE});
      S11: r = pick(sym, '{S12, ACT_NONE},  '{S1,  ACT_CLEAR},  '{S11, ACT_NONE});
      S12: r = pick(sym, '{S0,  ACT_FAULT}, '{S1,  ACT_MINUTE}, '{S12, ACT_NONE});
      default: r = pick(sym, '{S0, ACT_FAULT}, '{S1, ACT_CLEAR}, '{S0, ACT_NONE});
    endcase
    return r;
  endfunction

endpackage

### rtl/dcf_in_if.sv
// Tick request channel: one sampled pin level per request.
interface dcf_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

### rtl/dcf_out_if.sv
// Event channel: one decoded event code per transfer.
interface dcf_out_if;
  logic                     valid;
  logic                     ready;
  logic [dcf_pkg::CodeW-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

### rtl/dcf_cfg_regs.sv
// APB threshold register bank.
module dcf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcf_pkg::ApbAddrW-1:0] paddr,
  input  logic [dcf_pkg::ApbDataW-1:0] pwdata,
  output logic [dcf_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output dcf_pkg::thresh_arr_t         thresh_o
);

  dcf_pkg::thresh_arr_t             thresh_q;
  logic [dcf_pkg::RegIdxW-1:0]      idx;
  logic                             idx_ok;
  logic                             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[dcf_pkg::ApbAddrW-1:2];
  assign idx_ok = ({1'b0, idx} < (dcf_pkg::RegIdxW+1)'(dcf_pkg::NumThresh));
  assign wr_en  = psel && penable && pwrite && pready && idx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= dcf_pkg::ThreshReset;
    end else if (wr_en) begin
      thresh_q[idx] <= pwdata[dcf_pkg::ThreshW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = {{(dcf_pkg::ApbDataW-dcf_pkg::ThreshW){1'b0}}, thresh_q[idx]};
    end
  end

  assign thresh_o = thresh_q;

endmodule

### rtl/dcf_decoder.sv
// Tick register, transition logic, state/counter and event register.
module dcf_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dcf_pkg::thresh_arr_t thresh_i,
  dcf_in_if.sink               req_i,
  dcf_out_if.source            evt_o
);

  // input stage
  logic in_valid_q, in_valid_d;
  logic pin_q;
  logic advance;

  // decoder state
  dcf_pkg::state_e                state_q, state_d;
  logic [dcf_pkg::CountW-1:0]     tick_q, tick_d;

  // result stage
  logic                           out_valid_q, out_valid_d;
  logic [dcf_pkg::CodeW-1:0]      code_q, code_d;

  logic                           mark;
  dcf_pkg::sym_e                  sym;
  dcf_pkg::trans_t                tr;
  logic                           emit;
  logic [dcf_pkg::CodeW-1:0]      code_new;

  assign advance     = in_valid_q && (!out_valid_q || evt_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_comb begin
    mark = 1'b0;
    for (int k = 0; k < dcf_pkg::NumThresh; k++) begin
      if (tick_q == thresh_i[k]) mark = 1'b1;
    end
    if (mark)       sym = dcf_pkg::SYM_MARK;
    else if (pin_q) sym = dcf_pkg::SYM_HIGH;
    else            sym = dcf_pkg::SYM_LOW;
    tr = dcf_pkg::trans_lookup(state_q, sym);
  end

  always_comb begin
    emit     = 1'b1;
    code_new = dcf_pkg::CodeFault;
    case (tr.act)
      dcf_pkg::ACT_ZERO:   code_new = dcf_pkg::CodeZero;
      dcf_pkg::ACT_ONE:    code_new = dcf_pkg::CodeOne;
      dcf_pkg::ACT_MINUTE: code_new = dcf_pkg::CodeMinute;
      dcf_pkg::ACT_FAULT:  code_new = dcf_pkg::CodeFault;
      default:             emit     = 1'b0;
    endcase
  end

  always_comb begin
    in_valid_d  = in_valid_q;
    state_d     = state_q;
    tick_d      = tick_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    if (out_valid_q && evt_o.ready) out_valid_d = 1'b0;
    if (advance) begin
      in_valid_d = 1'b0;
      state_d    = tr.next;
      // clear-then-increment lands on one
      if (tr.act == dcf_pkg::ACT_CLEAR || tr.act == dcf_pkg::ACT_MINUTE) begin
        tick_d = dcf_pkg::CountW'(1);
      end else begin
        tick_d = tick_q + dcf_pkg::CountW'(1);
      end
      if (emit) begin
        out_valid_d = 1'b1;
        code_d      = code_new;
      end
    end
    if (req_i.valid && req_i.ready) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= dcf_pkg::S0;
      tick_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      tick_q      <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) pin_q <= req_i.pin_level;
    code_q <= code_d;
  end

  assign evt_o.valid      = out_valid_q;
  assign evt_o.event_code = code_q;

endmodule

### rtl/dcf77_pulse_classifier.sv
// Top level of the DCF77 pulse width classifier.
// Usage: req_i carries one request per 10 ms tick with the sampled receiver
//   pin level. evt_o returns an event code (zero bit, one bit, minute
//   mark or sampling fault) for the ticks that settle a bit, end a minute
//   gap or break the expected timing; most ticks return nothing.
//   Seven 8-bit timing marks sit on the APB port at byte addresses 0..24
//   (4 apart); pready is always high, writes land in the access cycle.
//   Reprogram them only while no tick is in flight.
// Timing: a request is registered in the tick register at acceptance,
//   classified by the threshold compare and table lookup once the
//   event register is free, and its event then waits there on evt_o.
//   One request per cycle is sustained while evt_o.ready is high; the limit
//   is the single state/counter register feeding the transition table.
// Stall: the event register holds its code while evt_o.ready is low; the
//   tick register keeps taking one more request, then req_i.ready drops
//   until the event is taken.
// Reset: rst_ni (async, low) returns the decoder to idle, zeroes the tick
//   counter, empties both stages and restores the default thresholds.
module dcf77_pulse_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcf_pkg::ApbAddrW-1:0] paddr,
  input  logic [dcf_pkg::ApbDataW-1:0] pwdata,
  output logic [dcf_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  dcf_in_if.sink                       req_i,
  dcf_out_if.source                    evt_o
);

  dcf_pkg::thresh_arr_t thresh;

  // threshold registers
  dcf_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .thresh_o (thresh)
  );

  // tick classification and event output
  dcf_decoder u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .thresh_i (thresh),
    .req_i    (req_i),
    .evt_o    (evt_o)
  );

endmodule

### sim/dcf_event_sb_pkg.sv
// Scoreboard for the pulse classifier: tick predictor and queue of due event codes.
`timescale 1ns / 100ps
package dcf_event_sb_pkg;
  import dcf_pkg::*;

  class dcf_event_scoreboard;
    thresh_arr_t       marks;
    state_e            fsm;
    logic [CountW-1:0] ticks;
    logic [CodeW-1:0]  due_codes[$];
    int                errors;
    int                matched;
    int                per_code[4];

    function new();
      // power-up timing marks, written out independently of the package
      marks = {8'd220, 8'd120, 8'd95, 8'd25, 8'd17, 8'd15, 8'd6};
      fsm = S0;
      ticks = '0;
      errors = 0;
      matched = 0;
      foreach (per_code[i]) per_code[i] = 0;
    endfunction

    function void set_mark(int idx, logic [ApbDataW-1:0] data);
      if (idx < NumThresh) marks[idx] = data[ThreshW-1:0];
    endfunction

    // one accepted tick request: advance decoder, queue the event it causes
    function void note_tick(logic level);
      sym_e   sym;
      state_e nxt;
      act_e   act;
      logic   hit;
      hit = 1'b0;
      for (int k = 0; k < NumThresh; k++) begin
        if (marks[k] == ticks) hit = 1'b1;
      end
      sym = hit ? SYM_MARK : (level ? SYM_HIGH : SYM_LOW);
      nxt = fsm;
      act = ACT_NONE;
      case (fsm)
        // pulse in progress: high holds, mark advances but is a fault in S8
        S1, S2, S7, S8: begin
          if (sym == SYM_MARK) begin
            case (fsm)
              S1: nxt = S2;
              S2: nxt = S7;
              S7: nxt = S8;
              default: begin
                nxt = S0;
                act = ACT_FAULT;
              end
            endcase
          end else if (sym == SYM_LOW) begin
            case (fsm)
              S2: nxt = S3;
              S8: nxt = S9;
              default: begin
                nxt = S0;
                act = ACT_FAULT;
              end
            endcase
          end
        end
        // low wait after pulse: low holds, high is a fault, mark advances
        S3, S4, S5, S6, S9, S10: begin
          if (sym == SYM_HIGH) begin
            nxt = S0;
            act = ACT_FAULT;
          end else if (sym == SYM_MARK) begin
            case (fsm)
              S3: nxt = S4;
              S4: nxt = S5;
              S5: nxt = S6;
              S6: begin
                nxt = S11;
                act = ACT_ZERO;
              end
              S9: nxt = S10;
              default: begin
                nxt = S11;
                act = ACT_ONE;
              end
            endcase
          end
        end
        // gap before next second, or minute gap
        S11, S12: begin
          if (sym == SYM_HIGH) begin
            nxt = S1;
            act = (fsm == S11) ? ACT_CLEAR : ACT_MINUTE;
          end else if (sym == SYM_MARK) begin
            if (fsm == S11) begin
              nxt = S12;
            end else begin
              nxt = S0;
              act = ACT_FAULT;
            end
          end
        end
        default: begin
          nxt = S0;
          if (sym == SYM_HIGH) begin
            nxt = S1;
            act = ACT_CLEAR;
          end else if (sym == SYM_MARK) begin
            act = ACT_FAULT;
          end
        end
      endcase
      fsm = nxt;
      case (act)
        ACT_CLEAR:  ticks = '0;
        ACT_MINUTE: begin
          ticks = '0;
          due_codes.push_back(CodeMinute);
        end
        ACT_ZERO:  due_codes.push_back(CodeZero);
        ACT_ONE:   due_codes.push_back(CodeOne);
        ACT_FAULT: due_codes.push_back(CodeFault);
        default: ;
      endcase
      ticks = ticks + 1'b1;
    endfunction

    function void check_event(logic [CodeW-1:0] code);
      logic [CodeW-1:0] want;
      if (due_codes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: event code %0d with nothing due", $time, code);
        return;
      end
      want = due_codes.pop_front();
      if (code !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: event code mismatch, expected %0d, got %0d", $time, want, code);
        end
      end else begin
        matched++;
        per_code[code]++;
      end
    endfunction

    function int outstanding();
      return due_codes.size();
    endfunction
  endclass

endpackage

### sim/tb_dcf77_pulse_classifier.sv
// Testbench for the DCF77 pulse classifier: tick stimulus, APB threshold setup, event check.
`timescale 1ns / 100ps
module tb_dcf77_pulse_classifier;
  import dcf_pkg::*;
  import dcf_event_sb_pkg::*;

  // generous bound for the worst case with full gaps and stalls
  localparam int CycleLimit = 200000;

  typedef enum int {
    PH_WF_RANDOM,  // random ascending marks, well-formed seconds
    PH_ALL_ZERO,   // every mark at 0
    PH_ALL_MAX,    // every mark at 255, long lows to wrap the counter
    PH_EQUAL,      // all marks equal
    PH_WF_MAX,     // well-formed with the minute limit at 255
    PH_NOISE,      // random marks, random pin
    PH_DEFAULTS    // power-up values written back
  } phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  dcf_in_if  req_if ();
  dcf_out_if evt_if ();

  dcf_event_scoreboard sb;

  int   cycles = 0;
  int   ticks_sent = 0;
  int   settings = 0;
  logic no_idle = 1'b0;  // phase-wide: both sides run back to back

  dcf77_pulse_classifier dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .evt_o   (evt_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_dcf77_pulse_classifier: done, errors");
      $finish;
    end
  end

  // One tick request. Handshake is sampled at the falling edge, so the
  // request counts as taken at the following rising edge.
  task automatic send_tick(input logic level);
    int   gap;
    logic taken;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.pin_level <= level;
    do begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
    end while (!taken);
    sb.note_tick(level);
    ticks_sent++;
  endtask

  // One second of signal: high_len ticks high, then low up to len ticks.
  task automatic send_second(input int high_len, input int len, input int flip_pct);
    logic lvl;
    for (int j = 0; j < len; j++) begin
      lvl = (j < high_len);
      if ($urandom_range(0, 99) < flip_pct) lvl = ~lvl;
      send_tick(lvl);
    end
  endtask

  task automatic run_noise(input int n, input int low_pct);
    repeat (n) send_tick($urandom_range(0, 99) >= low_pct);
  endtask

  // Mostly well-formed DCF77 seconds built from the current marks in
  // ascending order: zero pulses end between marks 0 and 1, one pulses
  // between marks 2 and 3; a gap ending between marks 4 and 5 is a plain
  // second, between 5 and 6 a minute mark. The rest are broken seconds.
  task automatic run_seconds(input int min_ticks);
    int t[NumThresh];
    int done;
    int p;
    int n;
    int r;
    int hi;
    int tmp;
    for (int k = 0; k < NumThresh; k++) t[k] = sb.marks[k];
    for (int a = 0; a < NumThresh - 1; a++) begin
      for (int b = 0; b < NumThresh - 1 - a; b++) begin
        if (t[b] > t[b+1]) begin
          tmp = t[b];
          t[b] = t[b+1];
          t[b+1] = tmp;
        end
      end
    end
    done = 0;
    while (done < min_ticks) begin
      r = $urandom_range(0, 99);
      if (r < 40) p = $urandom_range(t[0] + 1, t[1] - 1);
      else if (r < 80) p = $urandom_range(t[2] + 1, t[3] - 1);
      else p = $urandom_range(1, t[6]);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(t[4] + 1, t[5] - 1);
      end else if (r < 88) begin
        hi = (t[6] - 1 < t[5] + 40) ? t[6] - 1 : t[5] + 40;
        n = $urandom_range(t[5] + 1, hi);
      end else begin
        n = $urandom_range(1, t[6] + 4);
      end
      if (n < p) n = p;
      // most seconds clean, some with glitches on the pin
      send_second(p, n, ($urandom_range(0, 3) == 0) ? 4 : 0);
      done += n;
    end
  endtask

  // APB write; back-to-back writes keep psel high, caller closes the burst.
  task automatic write_reg(input int idx, input logic [ThreshW-1:0] val);
    logic [ApbDataW-1:0] data;
    logic                rdy;
    data = $urandom();
    // junk in the upper bits must be dropped by the block
    if (idx < NumThresh) data[ThreshW-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    sb.set_mark(idx, data);
  endtask

  // Shuffle the values over the registers, write all, then one write
  // past the last register, which must have no effect.
  task automatic program_marks(input logic [ThreshW-1:0] vals[NumThresh]);
    logic [ThreshW-1:0] v[NumThresh];
    logic [ThreshW-1:0] tmp;
    int                 j;
    v = vals;
    for (int k = NumThresh - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = v[k];
      v[k] = v[j];
      v[j] = tmp;
    end
    for (int k = 0; k < NumThresh; k++) write_reg(k, v[k]);
    write_reg(NumThresh, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings++;
  endtask

  // Drain: all due events taken, then a wait so that a last tick that
  // causes no event still updates state and counter.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Event sink: random stall before each event, then take it.
  initial begin
    int               stall;
    logic             hit;
    logic [CodeW-1:0] code;
    evt_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        evt_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      evt_if.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        hit  = evt_if.valid;
        code = evt_if.event_code;
        @(posedge clk_i);
      end while (!hit);
      sb.check_event(code);
    end
  end

  initial begin
    logic [ThreshW-1:0] vals[NumThresh];
    logic [ThreshW-1:0] same;
    phase_e             plan[11];
    plan = '{PH_WF_RANDOM, PH_ALL_ZERO, PH_WF_RANDOM, PH_ALL_MAX, PH_WF_RANDOM, PH_EQUAL,
             PH_WF_MAX, PH_WF_RANDOM, PH_NOISE, PH_WF_RANDOM, PH_DEFAULTS};
    sb = new();
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    req_if.valid     <= 1'b0;
    req_if.pin_level <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle line from reset: counter reaches the first power-up mark -> fault
    repeat (7) send_tick(1'b0);
    // power-up marks with real second timing
    run_seconds(100);

    // short marks: one zero second, one one second, then a minute gap
    settle();
    vals = '{8'd1, 8'd3, 8'd4, 8'd6, 8'd8, 8'd10, 8'd12};
    program_marks(vals);
    send_second(2, 9, 0);
    send_second(5, 11, 0);
    send_tick(1'b1);

    foreach (plan[p]) begin
      settle();
      no_idle = ($urandom_range(0, 3) == 0);
      case (plan[p])
        PH_WF_RANDOM: begin
          vals[0] = ThreshW'($urandom_range(1, 3));
          for (int k = 1; k < NumThresh; k++) begin
            vals[k] = vals[k-1] + ThreshW'($urandom_range(2, 4));
          end
          program_marks(vals);
          run_seconds(60);
        end
        PH_ALL_ZERO: begin
          foreach (vals[k]) vals[k] = '0;
          program_marks(vals);
          run_noise(60, 50);
        end
        PH_ALL_MAX: begin
          foreach (vals[k]) vals[k] = '1;
          program_marks(vals);
          // long low stretch: counter wraps through 255
          repeat (280) send_tick(1'b0);
          run_noise(30, 50);
        end
        PH_EQUAL: begin
          same = ThreshW'($urandom_range(1, 30));
          foreach (vals[k]) vals[k] = same;
          program_marks(vals);
          run_noise(70, 60);
        end
        PH_WF_MAX: begin
          vals = '{8'd1, 8'd3, 8'd5, 8'd7, 8'd9, 8'd11, 8'd255};
          program_marks(vals);
          run_seconds(100);
        end
        PH_NOISE: begin
          foreach (vals[k]) vals[k] = ThreshW'($urandom_range(0, 40));
          program_marks(vals);
          run_noise(60, 55);
        end
        default: begin
          vals = '{8'd6, 8'd15, 8'd17, 8'd25, 8'd95, 8'd120, 8'd220};
          program_marks(vals);
          run_seconds(150);
        end
      endcase
    end

    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d ticks under %0d programmed threshold sets plus power-up values",
             ticks_sent, settings);
    $display("events matched %0d: zero %0d, one %0d, minute %0d, fault %0d; mismatches %0d",
             sb.matched, sb.per_code[CodeZero], sb.per_code[CodeOne],
             sb.per_code[CodeMinute], sb.per_code[CodeFault], sb.errors);
    if (sb.errors == 0) begin
      $display("tb_dcf77_pulse_classifier: done, clean");
    end else begin
      $display("tb_dcf77_pulse_classifier: done, errors");
    end
    $finish;
  end

endmodule
